// File: hw/rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: page frame store pixel engine, shared definitions
// Screen geometry, store sizing, operation and colour codes, sweep types.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_PAGES   = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * STORE_PAGES;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int PW            = $clog2(STORE_PAGES + 1);

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr LAST_ADDR = t_addr'(STORE_BYTES - 1);

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] COL_BLACK   = 2'd0;
    localparam logic [1:0] COL_WHITE   = 2'd1;
    localparam logic [1:0] COL_INVERSE = 2'd2;

    localparam logic [7:0] FILL_BLACK = 8'h00;
    localparam logic [7:0] FILL_WHITE = 8'hFF;

    typedef enum logic {
        SW_IDLE,
        SW_RUN
    } t_sweep_state;

    // write request and status from the fill sequencer
    typedef struct packed {
        logic       busy;
        logic       wr_en;
        t_addr      addr;
        logic [7:0] data;
    } t_sweep;

endpackage

// File: hw/rtl/page_framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_engine: paged 1bpp frame store with pixel engine
// Draw, clear and byte readout over a page-organised monochrome store.
// ----------------------------------------------------------------------------
// Usage notes
//  - Command beat: taken on a rising edge with start high and busy low. Fields
//    are i_func, i_pixel_x, i_pixel_y, i_color and i_byte_index.
//  - Result beat: o_read_byte is valid for exactly one cycle with o_strobe
//    high, the cycle after a read beat was taken. The receiver cannot stall.
//  - Draws are read-modify-write via a two-step pipe that reads share: memory
//    read at the accept edge, modify and write back in the next cycle. While
//    busy is low a new beat may follow every cycle; a back-to-back hit on the
//    same byte is served from a forwarding register, keeping one beat per cycle.
//  - A clear (black or white) runs the fill sequencer: busy stays high while
//    it writes one byte per cycle over all STORE_BYTES (1024 at 128x64) bytes.
//  - Clear with inverse or colour 3, draw with colour 3, off-screen draws and
//    func 3 change nothing and give no result.
//  - Reset (synchronous) starts a black fill pass: busy stays high after reset
//    is released until every byte is written, then the store reads zero.
//  - Reads beyond the store give 0.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_pixel_x,
    input  logic signed [15:0] i_pixel_y,
    input  logic [1:0]         i_color,
    input  logic [9:0]         i_byte_index,
    output logic               o_strobe,
    output logic [7:0]         o_read_byte
);

    pfe_pkg::t_sweep sweep;

    logic           accept;
    logic           on_screen;
    logic [pfe_pkg::XW-1:0] x_col;
    logic [pfe_pkg::PW-1:0] y_page;
    pfe_pkg::t_addr draw_addr;
    pfe_pkg::t_addr rd_addr;
    logic           draw_wr;
    logic           read_go;
    logic           clear_go;
    logic [7:0]     clear_fill;

    // stage 1: byte from memory, modify, write back
    logic           r_s1_draw;
    logic           r_s1_read;
    logic           r_s1_oob;
    pfe_pkg::t_addr r_s1_addr;
    logic [2:0]     r_s1_bit;
    logic [1:0]     r_s1_color;
    logic           r_fwd_hit;
    logic [7:0]     r_fwd_data;

    logic [7:0]     mem_rdata;
    logic [7:0]     cur_byte;
    logic [7:0]     bit_mask;
    logic [7:0]     new_byte;

    logic           mem_we;
    pfe_pkg::t_addr mem_waddr;
    logic [7:0]     mem_wdata;

    assign busy   = sweep.busy;
    assign accept = start && !busy;

    // ---- decode of the command beat ----
    always_comb begin
        on_screen = !i_pixel_x[15] && !i_pixel_y[15]
                    && ($unsigned(i_pixel_x) < 16'(pfe_pkg::SCREEN_WIDTH))
                    && ($unsigned(i_pixel_y) < 16'(pfe_pkg::SCREEN_HEIGHT));
        x_col     = i_pixel_x[pfe_pkg::XW-1:0];
        y_page    = i_pixel_y[3 +: pfe_pkg::PW];
        // byte = x + page * width
        draw_addr = pfe_pkg::t_addr'(x_col)
                    + pfe_pkg::t_addr'(y_page)
                    * pfe_pkg::t_addr'(pfe_pkg::SCREEN_WIDTH);
        rd_addr   = (i_func == pfe_pkg::FUNC_DRAW) ? draw_addr
                                                   : pfe_pkg::t_addr'(i_byte_index);
        draw_wr   = accept && (i_func == pfe_pkg::FUNC_DRAW) && on_screen
                    && ((i_color == pfe_pkg::COL_BLACK)
                        || (i_color == pfe_pkg::COL_WHITE)
                        || (i_color == pfe_pkg::COL_INVERSE));
        read_go   = accept && (i_func == pfe_pkg::FUNC_READ);
        clear_go  = accept && (i_func == pfe_pkg::FUNC_CLEAR)
                    && ((i_color == pfe_pkg::COL_BLACK)
                        || (i_color == pfe_pkg::COL_WHITE));
        clear_fill = (i_color == pfe_pkg::COL_WHITE) ? pfe_pkg::FILL_WHITE
                                                     : pfe_pkg::FILL_BLACK;
    end

    // ---- stage 1 registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_draw <= 1'b0;
            r_s1_read <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_s1_draw <= draw_wr;
            r_s1_read <= read_go;
            // byte being written back now is read stale by the memory
            r_fwd_hit <= r_s1_draw && (rd_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= rd_addr;
        r_s1_bit   <= i_pixel_y[2:0];
        r_s1_color <= i_color;
        r_s1_oob   <= (32'(i_byte_index) >= pfe_pkg::STORE_BYTES);
        r_fwd_data <= new_byte;
    end

    // ---- modify ----
    always_comb begin
        cur_byte = r_fwd_hit ? r_fwd_data : mem_rdata;
        bit_mask = 8'h01 << r_s1_bit;
        case (r_s1_color)
            pfe_pkg::COL_WHITE:   new_byte = cur_byte | bit_mask;
            pfe_pkg::COL_BLACK:   new_byte = cur_byte & ~bit_mask;
            pfe_pkg::COL_INVERSE: new_byte = cur_byte ^ bit_mask;
            default:              new_byte = cur_byte;
        endcase
    end

    // ---- write port: fill sequencer or pixel write-back ----
    always_comb begin
        if (sweep.wr_en) begin
            mem_we    = 1'b1;
            mem_waddr = sweep.addr;
            mem_wdata = sweep.data;
        end else begin
            mem_we    = r_s1_draw;
            mem_waddr = r_s1_addr;
            mem_wdata = new_byte;
        end
    end

    assign o_strobe    = r_s1_read;
    assign o_read_byte = r_s1_oob ? 8'h00 : cur_byte;

    pfe_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    pfe_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (clear_go),
        .i_fill  (clear_fill),
        .o_sweep (sweep)
    );

    // ---- assertions ----
    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && (i_func == pfe_pkg::FUNC_READ)))
        else $error("result beat without a read beat");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sweep.wr_en && r_s1_draw))
        else $error("fill and pixel write-back collide");

    a_busy_from_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(busy) && $past(i_rst_n))
            |-> $past(start && (i_func == pfe_pkg::FUNC_CLEAR)))
        else $error("busy rose without a clear beat");

    a_no_pipe_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(busy) && $past(i_rst_n)) |-> (!r_s1_draw && !r_s1_read))
        else $error("pipe loaded while fill ran");

endmodule

// File: hw/rtl/pfe_store.sv
// ----------------------------------------------------------------------------
// pfe_store: frame store memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfe_store (
    input  logic           i_clk,
    input  logic           i_we,
    input  pfe_pkg::t_addr i_waddr,
    input  logic [7:0]     i_wdata,
    input  pfe_pkg::t_addr i_raddr,
    output logic [7:0]     o_rdata
);

    logic [7:0] r_mem [pfe_pkg::STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pfe_sweep.sv
// ----------------------------------------------------------------------------
// pfe_sweep: store fill sequencer
// Writes one fill byte per cycle over the whole store; runs black after reset.
// ----------------------------------------------------------------------------
module pfe_sweep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [7:0]      i_fill,
    output pfe_pkg::t_sweep o_sweep
);

    pfe_pkg::t_sweep_state r_state, n_state;
    pfe_pkg::t_addr        r_count, n_count;
    logic [7:0]            r_fill, n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfe_pkg::SW_RUN;
            r_count <= '0;
            r_fill  <= pfe_pkg::FILL_BLACK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fill  <= n_fill;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_fill  = r_fill;
        case (r_state)
            pfe_pkg::SW_IDLE: begin
                if (i_go) begin
                    n_state = pfe_pkg::SW_RUN;
                    n_count = '0;
                    n_fill  = i_fill;
                end
            end
            pfe_pkg::SW_RUN: begin
                if (r_count == pfe_pkg::LAST_ADDR) begin
                    n_state = pfe_pkg::SW_IDLE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_state = pfe_pkg::SW_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sweep.busy  = (r_state == pfe_pkg::SW_RUN);
        o_sweep.wr_en = (r_state == pfe_pkg::SW_RUN);
        o_sweep.addr  = r_count;
        o_sweep.data  = r_fill;
    end

endmodule
